>>> sv/mmgt_pkg.sv
// ----------------------------------------------------------------------------
// mmgt_pkg
// Shared widths and codes of the ordered multiset minimum-gap tracker.
// ----------------------------------------------------------------------------
package mmgt_pkg;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned CountBits = 16;
  localparam int unsigned AddrW     = $clog2(Capacity);
  localparam int unsigned OccW      = $clog2(Capacity + 1);
  localparam int unsigned ValueW    = 32;
  localparam int unsigned DcountW   = 7;

  localparam logic [CountBits-1:0] MultMax = {CountBits{1'b1}};

  localparam logic ActInsert = 1'b0;
  localparam logic ActErase  = 1'b1;

  typedef enum logic [1:0] {
    StDone   = 2'd0,
    StAbsent = 2'd1,
    StFull   = 2'd2
  } status_e;

  // Table entry: value with its multiplicity
  typedef struct packed {
    logic [ValueW-1:0]    value;
    logic [CountBits-1:0] count;
  } entry_t;

endpackage

>>> sv/mmgt_req_if.sv
// ----------------------------------------------------------------------------
// mmgt_req_if
// Request channel: one insert or erase per request.
// ----------------------------------------------------------------------------
interface mmgt_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic signed [31:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

>>> sv/mmgt_rsp_if.sv
// ----------------------------------------------------------------------------
// mmgt_rsp_if
// Result channel: minimum gap, validity, status and distinct count.
// ----------------------------------------------------------------------------
interface mmgt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] min_gap;
  logic        gap_valid;
  logic [1:0]  status;
  logic [6:0]  distinct_count;

  modport source (output valid, min_gap, gap_valid, status, distinct_count, input ready);
  modport sink   (input valid, min_gap, gap_valid, status, distinct_count, output ready);
endinterface

>>> sv/mmgt_ram.sv
// ----------------------------------------------------------------------------
// mmgt_ram
// Synchronous table memory with one read and one write port, registered read data.
// ----------------------------------------------------------------------------
module mmgt_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> sv/multiset_min_gap_tracker.sv
// ----------------------------------------------------------------------------
// multiset_min_gap_tracker
// Sorted multiset of signed values held in one table memory; reports the
// smallest gap between any two held elements after every request.
// ----------------------------------------------------------------------------
// Usage:
//   req  (sink):   action 0 inserts one copy of value, 1 erases one copy.
//   rsp  (source): min_gap, gap_valid, status, distinct_count; one per request.
// Each request is handled alone by a sequencer around one table memory
// (one read and one write port, registered read data):
//   a search sweep reads entries in order until it finds the position, a new
//   value or the erase of a last copy shifts the entries above it by one
//   (each read then written), a count change rewrites the entry in place,
//   and a gap sweep reads the N held entries when two or more are held and
//   none is duplicated.
// The result sits in an output register; the next request is taken the cycle
// after the result is loaded, even while the receiver stalls it, but the
// following result waits for the register to drain.
// Reset clears occupancy and duplicate count; table contents stay undefined
// and are never read beyond occupancy. No clearing pass is needed.
// ----------------------------------------------------------------------------
module multiset_min_gap_tracker (
  input  logic clk_i,
  input  logic rst_ni,
  mmgt_req_if.sink   req,
  mmgt_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    SIdle, SFind, SFindW, SDecide, SShUp, SShDn, SWrite, SGapRd, SGap, SOut
  } state_e;

  localparam int unsigned AW = mmgt_pkg::AddrW;
  localparam int unsigned OW = mmgt_pkg::OccW;

  state_e state_q;
  logic   act_q;
  logic [31:0] val_q;
  logic [OW-1:0] occ_q, idx_q, pos_q;
  logic [OW-1:0] dup_q;
  logic found_q;
  mmgt_pkg::entry_t hold_q;  // entry written in place or inserted
  logic [31:0] prev_q, gap_q;
  logic [1:0]  st_q;
  logic        gfirst_q;
  logic        phase_q;

  logic        rv_q, rgv_q;
  logic [31:0] rgap_q;
  logic [1:0]  rst_q;
  logic [6:0]  rdc_q;

  // memory port
  logic we;
  logic [AW-1:0] waddr, raddr;
  mmgt_pkg::entry_t wdata, rdata;

  mmgt_ram #(.Depth(mmgt_pkg::Capacity), .Width($bits(mmgt_pkg::entry_t))) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [31:0] key_in, key_rd, diff;
  assign key_in = val_q ^ 32'h8000_0000;
  assign key_rd = rdata.value ^ 32'h8000_0000;
  assign diff   = key_rd - prev_q;

  assign req.ready = (state_q == SIdle);
  assign rsp.valid = rv_q;
  assign rsp.min_gap = rgap_q;
  assign rsp.gap_valid = rgv_q;
  assign rsp.status = rst_q;
  assign rsp.distinct_count = rdc_q;

  // memory address and write control
  always_comb begin
    we = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = hold_q;
    raddr = idx_q[AW-1:0];
    case (state_q)
      // shift up: read idx-1, then copy it to idx; new entry lands at pos
      SShUp: begin
        raddr = AW'(idx_q - 1'b1);
        if (idx_q == pos_q) begin
          we = 1'b1;
        end else if (phase_q) begin
          we = 1'b1;
          wdata = rdata;
        end
      end
      // shift down: read idx+1, then copy it to idx
      SShDn: begin
        raddr = AW'(idx_q + 1'b1);
        if ((idx_q < occ_q) && phase_q) begin
          we = 1'b1;
          wdata = rdata;
        end
      end
      SWrite: begin
        we = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      occ_q <= '0; dup_q <= '0;
      idx_q <= '0; phase_q <= 1'b0;
    end else begin
      case (state_q)
        SIdle: if (req.valid) begin
          act_q <= req.action; val_q <= req.value;
          idx_q <= '0; st_q <= mmgt_pkg::StDone;
          state_q <= SFind;
        end
        // issue read of idx
        SFind: begin
          if (idx_q >= occ_q) begin
            pos_q <= idx_q; found_q <= 1'b0; state_q <= SDecide;
          end else state_q <= SFindW;
        end
        SFindW: begin
          if (key_rd < key_in) begin
            idx_q <= idx_q + 1'b1; state_q <= SFind;
          end else begin
            pos_q <= idx_q; found_q <= (rdata.value == val_q);
            hold_q <= rdata; state_q <= SDecide;
          end
        end
        SDecide: begin
          phase_q <= 1'b0;
          if (act_q == mmgt_pkg::ActInsert) begin
            if (found_q) begin
              if (hold_q.count != mmgt_pkg::MultMax) begin
                hold_q.count <= hold_q.count + 1'b1;
                if (hold_q.count == mmgt_pkg::CountBits'(1)) dup_q <= dup_q + 1'b1;
                idx_q <= pos_q; state_q <= SWrite;
              end else state_q <= SGapRd;
            end else if (occ_q == OW'(mmgt_pkg::Capacity)) begin
              st_q <= mmgt_pkg::StFull; state_q <= SGapRd;
            end else begin
              hold_q <= '{value: val_q, count: mmgt_pkg::CountBits'(1)};
              idx_q <= occ_q; state_q <= SShUp;
              occ_q <= occ_q + 1'b1;
            end
          end else begin
            if (!found_q) begin
              st_q <= mmgt_pkg::StAbsent; state_q <= SGapRd;
            end else if (hold_q.count > mmgt_pkg::CountBits'(1)) begin
              if (hold_q.count == mmgt_pkg::CountBits'(2)) dup_q <= dup_q - 1'b1;
              hold_q.count <= hold_q.count - 1'b1;
              idx_q <= pos_q; state_q <= SWrite;
            end else begin
              idx_q <= pos_q; occ_q <= occ_q - 1'b1; state_q <= SShDn;
            end
          end
        end
        // move entries up from the top down to pos, then place the new one
        SShUp: begin
          if (idx_q == pos_q) begin
            state_q <= SGapRd;
          end else if (!phase_q) begin
            phase_q <= 1'b1;
          end else begin
            phase_q <= 1'b0; idx_q <= idx_q - 1'b1;
          end
        end
        // close the hole at pos, moving entries down up to the new occupancy
        SShDn: begin
          if (idx_q >= occ_q) begin
            state_q <= SGapRd;
          end else if (!phase_q) begin
            phase_q <= 1'b1;
          end else begin
            phase_q <= 1'b0; idx_q <= idx_q + 1'b1;
          end
        end
        // in-place count update
        SWrite: state_q <= SGapRd;
        SGapRd: begin
          gfirst_q <= 1'b1; idx_q <= '0; phase_q <= 1'b0;
          if ((occ_q >= OW'(2)) && (dup_q == '0)) begin
            gap_q <= 32'hFFFF_FFFF; state_q <= SGap;
          end else begin
            gap_q <= '0; state_q <= SOut;
          end
        end
        // neighbour gap reduction; each entry is read, then compared in a second phase
        SGap: begin
          if (!phase_q) begin
            phase_q <= 1'b1;
          end else begin
            phase_q <= 1'b0;
            prev_q <= key_rd; gfirst_q <= 1'b0;
            if (!gfirst_q && diff < gap_q) gap_q <= diff;
            idx_q <= idx_q + 1'b1;
            if (idx_q + 1'b1 >= occ_q) state_q <= SOut;
          end
        end
        SOut: if (!rv_q || rsp.ready) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0; rgap_q <= '0; rgv_q <= 1'b0; rst_q <= '0; rdc_q <= '0;
    end else if ((state_q == SOut) && (!rv_q || rsp.ready)) begin
      rv_q <= 1'b1; rgap_q <= gap_q;
      rgv_q <= (occ_q >= OW'(2)) || (dup_q != '0);
      rst_q <= st_q; rdc_q <= 7'(occ_q);
    end else if (rsp.ready) begin
      rv_q <= 1'b0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(mmgt_pkg::Capacity)) else $error("occupancy overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> state_q == SIdle) else $error("ready outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.gap_valid == 1'b0) |-> rsp.min_gap == 32'd0)
    else $error("gap without validity");

endmodule

>>> verif/multiset_min_gap_tracker_test.sv
// ----------------------------------------------------------------------------
// multiset_min_gap_tracker_test
// Drives insert and erase requests with random gaps and stalls, predicts the
// sorted table with its multiplicities, and checks every result field.
// ----------------------------------------------------------------------------
module multiset_min_gap_tracker_test;

  typedef struct packed {
    logic [31:0] min_gap;
    logic        gap_valid;
    logic [1:0]  status;
    logic [6:0]  distinct_count;
  } gap_result_t;

  // Scoreboard: own copy of the multiset, queue of expected results
  class gap_scoreboard;
    logic [31:0]                    vals[mmgt_pkg::Capacity];
    logic [mmgt_pkg::CountBits-1:0] mults[mmgt_pkg::Capacity];
    int unsigned          occ;
    int unsigned          dups;
    gap_result_t          pending[$];
    int unsigned          errors;

    function new();
      occ = 0;
      dups = 0;
      errors = 0;
    endfunction

    function void note_request(logic act, logic [31:0] v);
      int unsigned pos;
      bit          found;
      gap_result_t r;
      logic [31:0] d;
      pos = 0;
      while (pos < occ && (vals[pos] ^ 32'h8000_0000) < (v ^ 32'h8000_0000)) pos++;
      found = pos < occ && vals[pos] == v;
      r = '0;
      r.status = mmgt_pkg::StDone;
      if (act == mmgt_pkg::ActInsert) begin
        if (found) begin
          if (mults[pos] != mmgt_pkg::MultMax) begin
            mults[pos]++;
            if (mults[pos] == 2) dups++;
          end
        end else if (occ >= mmgt_pkg::Capacity) begin
          r.status = mmgt_pkg::StFull;
        end else begin
          for (int i = occ; i > pos; i--) begin
            vals[i] = vals[i-1];
            mults[i] = mults[i-1];
          end
          vals[pos] = v;
          mults[pos] = 1;
          occ++;
        end
      end else begin
        if (!found) begin
          r.status = mmgt_pkg::StAbsent;
        end else if (mults[pos] > 1) begin
          if (mults[pos] == 2) dups--;
          mults[pos]--;
        end else begin
          for (int i = pos; i + 1 < occ; i++) begin
            vals[i] = vals[i+1];
            mults[i] = mults[i+1];
          end
          occ--;
        end
      end
      r.gap_valid = occ >= 2 || dups > 0;
      if (r.gap_valid && dups == 0) begin
        r.min_gap = '1;
        for (int i = 1; i < occ; i++) begin
          d = vals[i] - vals[i-1];
          if (d < r.min_gap) r.min_gap = d;
        end
      end
      r.distinct_count = occ[6:0];
      pending.push_back(r);
    endfunction

    function void check_result(gap_result_t got);
      gap_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.min_gap !== e.min_gap) begin
        $error("min_gap: expected %0h, got %0h", e.min_gap, got.min_gap);
        errors++;
      end
      if (got.gap_valid !== e.gap_valid) begin
        $error("gap_valid: expected %0b, got %0b", e.gap_valid, got.gap_valid);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.distinct_count !== e.distinct_count) begin
        $error("distinct_count: expected %0d, got %0d", e.distinct_count,
               got.distinct_count);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned WatchLimit = 20000;

  logic clk_i;
  logic rst_ni;
  mmgt_req_if req ();
  mmgt_rsp_if rsp ();
  gap_scoreboard sb;
  int unsigned idle_cycles;
  bit          calm;
  logic [31:0] held_vals[$];

  multiset_min_gap_tracker uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req.sink),
    .rsp   (rsp.source)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Send one request, with an occasional gap first; valid stays up after
  // acceptance only until the next request or the end of stimulus replaces it
  task automatic send_request(logic act, logic [31:0] v);
    if (!calm && $urandom_range(99) < 8) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 8) @(posedge clk_i);
    end
    req.valid  <= 1'b1;
    req.action <= act;
    req.value  <= v;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    sb.note_request(act, v);
  endtask

  // Pick a value, mostly held or near what is held, so erases and duplicates hit
  function automatic logic [31:0] pick_value();
    int unsigned k;
    k = $urandom_range(9);
    if (held_vals.size() > 0 && k < 5)
      return held_vals[$urandom_range(held_vals.size() - 1)];
    if (held_vals.size() > 0 && k < 7)
      return held_vals[$urandom_range(held_vals.size() - 1)] + $urandom_range(7) - 3;
    if (k == 7) return $urandom_range(60) - 30;
    return $urandom();
  endfunction

  // Result side: random stalls, check on every accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready)
        sb.check_result({rsp.min_gap, rsp.gap_valid, rsp.status, rsp.distinct_count});
      rsp.ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  // Watchdog on cycles with no accepted request or result
  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic        act;
    logic [31:0] v;
    int unsigned n;
    sb = new();
    calm = 1'b0;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.action = mmgt_pkg::ActInsert;
    req.value = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty erase, single element, extremes, duplicate, absent erase
    send_request(mmgt_pkg::ActErase, 32'd5);
    send_request(mmgt_pkg::ActInsert, 32'h8000_0000);
    send_request(mmgt_pkg::ActInsert, 32'h7fff_ffff);
    send_request(mmgt_pkg::ActInsert, 32'h7fff_ffff);
    send_request(mmgt_pkg::ActErase, 32'h7fff_ffff);
    send_request(mmgt_pkg::ActErase, 32'h7fff_ffff);
    send_request(mmgt_pkg::ActInsert, 32'hffff_ffff);
    send_request(mmgt_pkg::ActInsert, 32'h0);
    send_request(mmgt_pkg::ActErase, 32'h1234_5678);
    send_request(mmgt_pkg::ActErase, 32'h8000_0000);
    send_request(mmgt_pkg::ActErase, 32'hffff_ffff);
    send_request(mmgt_pkg::ActErase, 32'h0);
    // Fill the table, then overflow it, then erase everything
    for (int i = 0; i < mmgt_pkg::Capacity; i++)
      send_request(mmgt_pkg::ActInsert, i * 3 - 90);
    send_request(mmgt_pkg::ActInsert, 32'h5555_5555);
    send_request(mmgt_pkg::ActInsert, 32'd0);
    send_request(mmgt_pkg::ActErase, 32'd0);
    for (int i = 0; i < mmgt_pkg::Capacity; i++)
      send_request(mmgt_pkg::ActErase, i * 3 - 90);

    // Random: mostly valid operations on held values, some noise
    n = 0;
    while (n < 1660) begin
      if (n % 600 >= 450) calm = 1'b1;
      else calm = 1'b0;
      act = (held_vals.size() > 40) ? ($urandom_range(99) < 65)
                                    : ($urandom_range(99) < 35);
      v = pick_value();
      send_request(act, v);
      if (act == mmgt_pkg::ActInsert) begin
        held_vals.push_back(v);
      end else begin
        foreach (held_vals[i]) begin
          if (held_vals[i] == v) begin
            held_vals.delete(i);
            break;
          end
        end
      end
      n++;
    end
    req.valid <= 1'b0;
    calm = 1'b0;

    // Drain, then settle
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
